// ===== hdl/bipc_pkg.sv =====
// Shared types and constants for the binomial interval probability core.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps
package bipc_pkg;

  localparam int unsigned COEF_W    = 62;   // mantissa and coefficient width
  localparam int unsigned EXP_W     = 9;    // shift count, holds MAX_SHIFT plus a full shift
  localparam int unsigned MAX_SHIFT = 200;
  localparam int unsigned ACC_W     = 125;  // 62 x 63 bit product
  localparam int unsigned SUM_W     = 33;   // Q1.32 result
  localparam int unsigned CNT_W     = 6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BUILD,
    ST_SKIP,
    ST_LOAD_TERM,
    ST_NORM,
    ST_DECIDE,
    ST_MUL,
    ST_MUL_END,
    ST_TERM_END,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic load;        // latch item, reset row, clear counters and sum
    logic row_pascal;  // advance the coefficient row by one trial
    logic row_shift;   // move the row down by one count
    logic i_inc;
    logic k_inc;
    logic term_load;   // start a term from the row head
    logic norm_shift;
    logic norm_check;
    logic mul_step;
    logic mul_end;
    logic accum;
  } cmd_t;

  typedef struct packed {
    logic i_eq_n;
    logic k_eq_lo;
    logic k_eq_hi;
    logic empty;
    logic m_zero;
    logic m_norm;
    logic pp_last;
  } sts_t;

endpackage

// ===== hdl/bipc_dp.sv =====
// Datapath: coefficient row, mantissa/shift term unit, partial product
// multiplier and saturating sum. Depends on bipc_pkg; driven by bipc_ctrl.
`timescale 1ns / 1ps
module bipc_dp #(
  parameter int unsigned MAX_TRIALS     = 32,
  parameter int unsigned PROB_FRAC_BITS = 16
) (
  input  logic                         clk_i,
  input  bipc_pkg::cmd_t               cmd_i,
  input  logic [PROB_FRAC_BITS:0]      prob_i,
  input  logic [bipc_pkg::CNT_W-1:0]   trials_i,
  input  logic [bipc_pkg::CNT_W-1:0]   low_i,
  input  logic [bipc_pkg::CNT_W-1:0]   high_i,
  output bipc_pkg::sts_t               sts_o,
  output logic [bipc_pkg::SUM_W-1:0]   sum_o
);
  import bipc_pkg::*;

  localparam int unsigned DEPTH = MAX_TRIALS + 1;
  localparam int unsigned P_SH  = 62 - PROB_FRAC_BITS;
  localparam logic [PROB_FRAC_BITS:0] ONE_P = {1'b1, {PROB_FRAC_BITS{1'b0}}};
  localparam logic [62:0] ONE62 = {1'b1, 62'd0};
  localparam logic [SUM_W-1:0] ONE32 = {1'b1, 32'd0};

  logic [COEF_W-1:0] coef_q [DEPTH];
  logic [62:0]       p62_q;
  logic [CNT_W-1:0]  n_q, lo_q, hi_q, i_q, k_q;
  logic [COEF_W-1:0] m_q;
  logic [EXP_W-1:0]  e_q;
  logic [ACC_W-1:0]  acc_q;
  logic [1:0]        pp_q;
  logic [SUM_W-1:0]  sum_q;

  logic [PROB_FRAC_BITS:0] p_c;
  logic [CNT_W-1:0]        n_c, hi_c;
  logic [62:0]             q62, y;
  logic [31:0]             mul_a, mul_b;
  logic [63:0]             pp;
  logic [ACC_W-1:0]        pp_sh, acc_d;
  logic [EXP_W-1:0]        sh;
  logic [COEF_W-1:0]       t_shift;
  logic [SUM_W-1:0]        term;
  logic [SUM_W:0]          sum_add;

  always_comb begin
    p_c  = (prob_i > ONE_P) ? ONE_P : prob_i;
    n_c  = (trials_i > CNT_W'(MAX_TRIALS)) ? CNT_W'(MAX_TRIALS) : trials_i;
    hi_c = (high_i > n_c) ? n_c : high_i;
    q62  = ONE62 - p62_q;
    y    = (i_q < k_q) ? p62_q : q62;
  end

  // one 32x32 partial product per cycle
  always_comb begin
    case (pp_q)
      2'd0: begin
        mul_a = m_q[31:0];
        mul_b = y[31:0];
      end
      2'd1: begin
        mul_a = m_q[31:0];
        mul_b = {1'b0, y[62:32]};
      end
      2'd2: begin
        mul_a = {2'b00, m_q[61:32]};
        mul_b = y[31:0];
      end
      default: begin
        mul_a = {2'b00, m_q[61:32]};
        mul_b = {1'b0, y[62:32]};
      end
    endcase
    pp = mul_a * mul_b;
    case (pp_q)
      2'd0:    pp_sh = ACC_W'(pp);
      2'd3:    pp_sh = ACC_W'(pp) << 64;
      default: pp_sh = ACC_W'(pp) << 32;
    endcase
    acc_d = ((pp_q == 2'd0) ? '0 : acc_q) + pp_sh;
  end

  // term in Q1.32 from the normalized mantissa and shift
  always_comb begin
    sh      = e_q - EXP_W'(32);
    t_shift = m_q >> sh[5:0];
    if (m_q == '0) begin
      term = '0;
    end else if (e_q <= EXP_W'(32)) begin
      term = ONE32;
    end else if (sh >= EXP_W'(64)) begin
      term = '0;
    end else if (t_shift > COEF_W'(ONE32)) begin
      term = ONE32;
    end else begin
      term = t_shift[SUM_W-1:0];
    end
    sum_add = {1'b0, sum_q} + {1'b0, term};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      p62_q <= 63'(p_c) << P_SH;
      n_q   <= n_c;
      lo_q  <= low_i;
      hi_q  <= hi_c;
      sum_q <= '0;
    end else if (cmd_i.accum) begin
      sum_q <= (sum_add > (SUM_W+1)'(ONE32)) ? ONE32 : sum_add[SUM_W-1:0];
    end

    for (int j = 0; j < DEPTH; j++) begin
      if (cmd_i.load) begin
        coef_q[j] <= (j == 0) ? COEF_W'(1) : '0;
      end else if (cmd_i.row_pascal && j > 0) begin
        coef_q[j] <= coef_q[j] + coef_q[(j+DEPTH-1) % DEPTH];
      end else if (cmd_i.row_shift) begin
        coef_q[j] <= (j == DEPTH-1) ? '0 : coef_q[(j+1) % DEPTH];
      end
    end

    if (cmd_i.load || cmd_i.term_load) begin
      i_q <= '0;
    end else if (cmd_i.i_inc) begin
      i_q <= i_q + CNT_W'(1);
    end

    if (cmd_i.load) begin
      k_q <= '0;
    end else if (cmd_i.k_inc) begin
      k_q <= k_q + CNT_W'(1);
    end

    if (cmd_i.term_load) begin
      m_q <= coef_q[0];
      e_q <= '0;
    end else if (cmd_i.norm_shift) begin
      m_q <= {m_q[COEF_W-2:0], 1'b0};
      e_q <= e_q + EXP_W'(1);
    end else if (cmd_i.norm_check) begin
      if (e_q > EXP_W'(MAX_SHIFT)) m_q <= '0;
    end else if (cmd_i.mul_end) begin
      m_q <= acc_q[123:62];
    end

    if (cmd_i.load) begin
      pp_q <= '0;
    end else if (cmd_i.mul_step) begin
      acc_q <= acc_d;
      pp_q  <= pp_q + 2'd1;
    end
  end

  assign sts_o.i_eq_n  = (i_q == n_q);
  assign sts_o.k_eq_lo = (k_q == lo_q);
  assign sts_o.k_eq_hi = (k_q == hi_q);
  assign sts_o.empty   = (lo_q > hi_q);
  assign sts_o.m_zero  = (m_q == '0);
  assign sts_o.m_norm  = m_q[COEF_W-1];
  assign sts_o.pp_last = (pp_q == 2'd3);
  assign sum_o         = sum_q;

endmodule

// ===== hdl/bipc_ctrl.sv =====
// Controller: sequences row build, term normalize/multiply loops and the
// final hand-off. Depends on bipc_pkg; commands bipc_dp.
`timescale 1ns / 1ps
module bipc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            out_free_i,
  output logic            out_load_o,
  input  bipc_pkg::sts_t  sts_i,
  output bipc_pkg::cmd_t  cmd_o
);
  import bipc_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    out_load_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_BUILD;
        end
      end
      ST_BUILD: begin
        if (sts_i.i_eq_n) begin
          state_d = sts_i.empty ? ST_FINISH : ST_SKIP;
        end else begin
          cmd_o.row_pascal = 1'b1;
          cmd_o.i_inc      = 1'b1;
        end
      end
      ST_SKIP: begin
        if (sts_i.k_eq_lo) begin
          state_d = ST_LOAD_TERM;
        end else begin
          cmd_o.row_shift = 1'b1;
          cmd_o.k_inc     = 1'b1;
        end
      end
      ST_LOAD_TERM: begin
        cmd_o.term_load = 1'b1;
        state_d         = ST_NORM;
      end
      ST_NORM: begin
        if (!sts_i.m_zero && !sts_i.m_norm) begin
          cmd_o.norm_shift = 1'b1;
        end else begin
          cmd_o.norm_check = 1'b1;
          state_d          = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_d = (sts_i.m_zero || sts_i.i_eq_n) ? ST_TERM_END : ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul_step = 1'b1;
        if (sts_i.pp_last) state_d = ST_MUL_END;
      end
      ST_MUL_END: begin
        cmd_o.mul_end = 1'b1;
        cmd_o.i_inc   = 1'b1;
        state_d       = ST_NORM;
      end
      ST_TERM_END: begin
        cmd_o.accum = 1'b1;
        if (sts_i.k_eq_hi) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.row_shift = 1'b1;
          cmd_o.k_inc     = 1'b1;
          state_d         = ST_LOAD_TERM;
        end
      end
      ST_FINISH: begin
        if (out_free_i) begin
          out_load_o = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load_o |-> out_free_i) else $error("result loaded into a full slot");
  a_mul_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL && sts_i.pp_last) |=> state_q == ST_MUL_END)
    else $error("multiply did not close after last partial product");
  a_norm_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_NORM && !sts_i.m_zero && !sts_i.m_norm) |=> state_q == ST_NORM)
    else $error("normalize left early");

endmodule

// ===== hdl/binomial_interval_probability_core.sv =====
// Operation: the coefficient row is built over n trials, where n is the clamped trial count,
// then each term from low to high is normalized one bit per cycle and multiplied by p or 1-p
// once per trial on the shared 32x32 multiplier, which forms each product from partial products.
// Throughput: one item at a time; the next item is taken while the result waits in the
// output register. Reset clears the controller and the output valid flag.
`timescale 1ns / 1ps
module binomial_interval_probability_core #(
  parameter int unsigned MAX_TRIALS     = 32,
  parameter int unsigned PROB_FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // success_prob, trials, low_count, high_count
  input  logic [((PROB_FRAC_BITS+19+7)/8)*8-1:0] s_axis_tdata_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // probability
  output logic [39:0]          m_axis_tdata_o
);
  import bipc_pkg::*;

  localparam int unsigned PW = PROB_FRAC_BITS + 1;

  cmd_t             cmd;
  sts_t             sts;
  logic             out_load, out_free;
  logic             out_valid_q;
  logic [SUM_W-1:0] out_data_q, sum;

  assign out_free = !out_valid_q || m_axis_tready_i;

  bipc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .out_free_i (out_free),
    .out_load_o (out_load),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bipc_dp #(
    .MAX_TRIALS     (MAX_TRIALS),
    .PROB_FRAC_BITS (PROB_FRAC_BITS)
  ) u_dp (
    .clk_i    (clk_i),
    .cmd_i    (cmd),
    .prob_i   (s_axis_tdata_i[PW-1:0]),
    .trials_i (s_axis_tdata_i[PW+5:PW]),
    .low_i    (s_axis_tdata_i[PW+11:PW+6]),
    .high_i   (s_axis_tdata_i[PW+17:PW+12]),
    .sts_o    (sts),
    .sum_o    (sum)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_data_q <= sum;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, out_data_q};

  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (out_data_q <= {1'b1, 32'd0}))
    else $error("result above one");

endmodule
